/* sv/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, constants and sequence helpers for the TCP segment reassembly
// block.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVERLAP = 3'd1;
    localparam logic [2:0] ST_BEFORE  = 3'd2;
    localparam logic [2:0] ST_CACHED  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] DL_NONE = 2'd0;
    localparam logic [1:0] DL_RAW  = 2'd1;
    localparam logic [1:0] DL_BUF  = 2'd2;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_MAXLEN = 1'b1;

    localparam logic [15:0] MAXLEN_RESET = 16'd8192;

    typedef enum logic [2:0] {
        CLS_RESTART,
        CLS_PASS,
        CLS_BEFORE,
        CLS_FULL,
        CLS_CACHE,
        CLS_RAWADV,
        CLS_MERGE
    } seg_class_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_merge;
        logic walk_end;
        logic out_free;
    } dp_status_t;

    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic seq_leq(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_lt(a, b);
    endfunction

endpackage

/* sv/tcp_segment_reassembly_top.sv */
// ----------------------------------------------------------------------------
// tcp_segment_reassembly_top
// Descriptor-level TCP reassembly for one stream direction.
// ----------------------------------------------------------------------------
// An item is taken in while the sequencer is idle and is then classified, and
// a segment that passes, is dropped or is cached then completes. A segment
// that merges then visits the table entries at the head of the sorted table
// one at a time (up to 16), and a closing step ends the walk. Classification
// and every walk step wait for the output register to be free. No new item is
// taken until the walk ends. Configuration writes are always ready.
module tcp_segment_reassembly_top
    import tsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] seq_number,
    input  logic [15:0] seg_length,
    input  logic [7:0]  header_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  delivered,
    output logic [31:0] out_seq,
    output logic [15:0] out_length,
    output logic [15:0] overlap_bytes,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    tsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tsr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .kind          (kind),
        .seq_number    (seq_number),
        .seg_length    (seg_length),
        .header_len    (header_len),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .delivered     (delivered),
        .out_seq       (out_seq),
        .out_length    (out_length),
        .overlap_bytes (overlap_bytes),
        .last          (last)
    );

endmodule

/* sv/tsr_ctrl.sv */
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer: takes an item, classifies it, then walks the table head for a merge.
// ----------------------------------------------------------------------------
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_MERGE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (dp_status.out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = dp_status.is_merge ? S_MERGE : S_IDLE;
                end
            end
            S_MERGE:
            begin
                if (dp_status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (dp_status.walk_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* sv/tsr_datapath.sv */
// ----------------------------------------------------------------------------
// tsr_datapath
// Base sequence, sorted segment table, merge registers and result register.
// ----------------------------------------------------------------------------
module tsr_datapath
    import tsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  dp_status,
    input  logic        kind,
    input  logic [31:0] seq_number,
    input  logic [15:0] seg_length,
    input  logic [7:0]  header_len,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  delivered,
    output logic [31:0] out_seq,
    output logic [15:0] out_length,
    output logic [15:0] overlap_bytes,
    output logic        last
);

    logic             enable_reg;
    logic [15:0]      maxlen_reg;
    logic [31:0]      base_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      tseq_reg [TABLE_DEPTH];
    logic [15:0]      tlen_reg [TABLE_DEPTH];
    logic [7:0]       thdr_reg [TABLE_DEPTH];

    logic             kind_reg;
    logic [31:0]      seq_reg;
    logic [15:0]      len_reg;
    logic [7:0]       hdr_reg;

    logic [31:0]      cseq_reg;
    logic [15:0]      clen_reg;
    logic [7:0]       chdr_reg;
    logic [31:0]      cend_reg;
    logic             first_reg;
    logic [15:0]      ovl_reg;

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [1:0]       deliv_reg;
    logic [31:0]      oseq_reg;
    logic [15:0]      olen_reg;
    logic [15:0]      oovl_reg;
    logic             last_reg;

    logic [31:0]      seg_end;
    logic [31:0]      ovl_full;
    logic [15:0]      ovl;
    logic             tbl_empty;
    logic             tbl_full;
    seg_class_t       cls;
    logic [TABLE_DEPTH-1:0] le_vec;
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [IDX_W-1:0] tail_idx;
    logic [CNT_W-1:0] ins_pos;
    logic [31:0]      head_end;
    logic [31:0]      add_full;
    logic [15:0]      add;
    logic [17:0]      fill_sum;
    logic             head_touch;
    logic             walk_end;
    logic             skip;
    logic             split;
    logic             do_insert;
    logic             do_consume;

    logic             emit;
    logic [2:0]       e_status;
    logic [1:0]       e_deliv;
    logic [31:0]      e_seq;
    logic [15:0]      e_len;
    logic [15:0]      e_ovl;
    logic             e_last;
    logic             out_free;

    assign seg_end   = seq_reg + {16'd0, len_reg};
    assign ovl_full  = seg_end - base_reg;
    assign ovl       = (seq_reg == base_reg) ? 16'd0 : ovl_full[15:0];
    assign tbl_empty = (count_reg == '0);
    assign tbl_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign tail_idx  = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        if (kind_reg == KIND_RESTART)
        begin
            cls = CLS_RESTART;
        end
        else if (!enable_reg || (len_reg == 16'd0))
        begin
            cls = CLS_PASS;
        end
        else if (seq_leq(seg_end, base_reg))
        begin
            cls = CLS_BEFORE;
        end
        else if (seq_lt(base_reg, seq_reg))
        begin
            cls = tbl_full ? CLS_FULL : CLS_CACHE;
        end
        else if (tbl_empty || seq_lt(seg_end, tseq_reg[0]))
        begin
            cls = CLS_RAWADV;
        end
        else
        begin
            cls = CLS_MERGE;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            le_vec[i] = (CNT_W'(i) < count_reg) && seq_leq(seq_reg, tseq_reg[i]);
            lt_vec[i] = !seq_leq(tseq_reg[i], seq_reg);
        end
    end

    always_comb
    begin
        ins_pos = count_reg;
        if (!tbl_empty && lt_vec[tail_idx])
        begin
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            begin
                if (le_vec[i])
                begin
                    ins_pos = CNT_W'(i);
                end
            end
        end
    end

    assign head_end   = tseq_reg[0] + {16'd0, tlen_reg[0]};
    assign head_touch = (cend_reg == tseq_reg[0]);
    assign add_full   = head_end - cend_reg;
    assign add        = head_touch ? tlen_reg[0] : add_full[15:0];
    assign walk_end   = tbl_empty || (!head_touch && !seq_lt(tseq_reg[0], cend_reg));
    assign skip       = !walk_end && !head_touch && seq_leq(head_end, cend_reg);
    assign fill_sum   = {10'd0, chdr_reg} + {2'd0, clen_reg} + {2'd0, add};
    assign split      = (fill_sum > {2'd0, maxlen_reg});
    assign do_insert  = cmd.eval && (cls == CLS_CACHE);
    assign do_consume = cmd.step && !walk_end;

    assign out_free = !out_valid_reg || !out_stall;
    assign dp_status.is_merge = (cls == CLS_MERGE);
    assign dp_status.walk_end = walk_end;
    assign dp_status.out_free = out_free;

    always_comb
    begin
        emit     = 1'b0;
        e_status = ST_OK;
        e_deliv  = DL_NONE;
        e_seq    = 32'd0;
        e_len    = 16'd0;
        e_ovl    = 16'd0;
        e_last   = 1'b1;
        if (cmd.eval)
        begin
            emit = 1'b1;
            case (cls)
                CLS_RESTART:
                begin
                    e_status = ST_OK;
                end
                CLS_PASS:
                begin
                    e_deliv = DL_RAW;
                    e_seq   = seq_reg;
                    e_len   = len_reg;
                end
                CLS_BEFORE:
                begin
                    e_status = ST_BEFORE;
                    e_deliv  = DL_RAW;
                    e_seq    = seq_reg;
                    e_len    = len_reg;
                end
                CLS_FULL:
                begin
                    e_status = ST_FULL;
                end
                CLS_CACHE:
                begin
                    e_status = ST_CACHED;
                end
                CLS_RAWADV:
                begin
                    e_status = (seq_reg == base_reg) ? ST_OK : ST_OVERLAP;
                    e_deliv  = DL_RAW;
                    e_seq    = seq_reg;
                    e_len    = len_reg;
                    e_ovl    = ovl;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if (cmd.step && (walk_end || (!skip && split)))
        begin
            emit    = 1'b1;
            e_deliv = DL_BUF;
            e_seq   = cseq_reg;
            e_len   = clen_reg;
            e_ovl   = first_reg ? ovl_reg : 16'd0;
            e_last  = walk_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            maxlen_reg    <= MAXLEN_RESET;
            base_reg      <= 32'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ENABLE: enable_reg <= cfg_data[0];
                    CFG_MAXLEN: maxlen_reg <= cfg_data;
                    default:    enable_reg <= enable_reg;
                endcase
            end
            if (cmd.eval)
            begin
                case (cls)
                    CLS_RESTART:
                    begin
                        base_reg  <= seq_reg;
                        count_reg <= '0;
                    end
                    CLS_CACHE:
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    CLS_RAWADV, CLS_MERGE:
                    begin
                        base_reg <= seg_end;
                    end
                    default:
                    begin
                        base_reg <= base_reg;
                    end
                endcase
            end
            if (do_consume)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (!skip)
                begin
                    base_reg <= head_end;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            seq_reg  <= seq_number;
            len_reg  <= seg_length;
            hdr_reg  <= header_len;
        end
        if (cmd.eval)
        begin
            cseq_reg  <= seq_reg;
            clen_reg  <= len_reg;
            chdr_reg  <= hdr_reg;
            cend_reg  <= seg_end;
            first_reg <= 1'b1;
            ovl_reg   <= ovl;
        end
        if (do_consume && !skip)
        begin
            cend_reg <= head_end;
            if (split)
            begin
                cseq_reg  <= cend_reg;
                clen_reg  <= add;
                chdr_reg  <= thdr_reg[0];
                first_reg <= 1'b0;
            end
            else
            begin
                clen_reg <= clen_reg + add;
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (do_insert)
            begin
                if (CNT_W'(i) == ins_pos)
                begin
                    tseq_reg[i] <= seq_reg;
                    tlen_reg[i] <= len_reg;
                    thdr_reg[i] <= hdr_reg;
                end
                else if ((i > 0) && (CNT_W'(i) > ins_pos) && (CNT_W'(i) <= count_reg))
                begin
                    tseq_reg[i] <= tseq_reg[(i > 0) ? i - 1 : 0];
                    tlen_reg[i] <= tlen_reg[(i > 0) ? i - 1 : 0];
                    thdr_reg[i] <= thdr_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_consume && (i < TABLE_DEPTH - 1))
            begin
                tseq_reg[i] <= tseq_reg[(i < TABLE_DEPTH - 1) ? i + 1 : i];
                tlen_reg[i] <= tlen_reg[(i < TABLE_DEPTH - 1) ? i + 1 : i];
                thdr_reg[i] <= thdr_reg[(i < TABLE_DEPTH - 1) ? i + 1 : i];
            end
        end
        if (emit)
        begin
            status_reg <= e_status;
            deliv_reg  <= e_deliv;
            oseq_reg   <= e_seq;
            olen_reg   <= e_len;
            oovl_reg   <= e_ovl;
            last_reg   <= e_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign delivered     = deliv_reg;
    assign out_seq       = oseq_reg;
    assign out_length    = olen_reg;
    assign overlap_bytes = oovl_reg;
    assign last          = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow table");

    a_consume_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_consume |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("consume did not shrink table");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TCP segment reassembly block. A driver sends
// segment descriptors from a queue, a predictor computes the expected results
// per segment, and a monitor compares every delivered result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [15:0] len;
        logic [7:0]  hdr;
    } segment_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  delivered;
        logic [31:0] seq;
        logic [15:0] len;
        logic [15:0] ovl;
        logic        last;
    } delivery_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic [7:0]  hdr;
    } cached_seg_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] seq_number;
    logic [15:0] seg_length;
    logic [7:0]  header_len;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [1:0]  delivered;
    logic [31:0] out_seq;
    logic [15:0] out_length;
    logic [15:0] overlap_bytes;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    segment_t    pending_segs[$];
    delivery_t   expected_deliveries[$];
    cached_seg_t seg_cache[$];
    logic [31:0] next_seq;
    logic        enable_q;
    logic [15:0] buf_limit;
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          quiet_in;
    bit          quiet_out;
    int          hold_out;

    tcp_segment_reassembly_top dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit seq_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void push_delivery(logic [2:0] st, logic [1:0] dl, logic [31:0] sq,
                                          logic [15:0] ln, logic [15:0] ov, logic lst);
        delivery_t d;
        d.status = st;
        d.delivered = dl;
        d.seq = sq;
        d.len = ln;
        d.ovl = ov;
        d.last = lst;
        expected_deliveries.push_back(d);
    endfunction

    function automatic void predict_reassembly(segment_t s);
        logic [31:0] seg_end;
        logic [31:0] ovl;
        logic [31:0] cur_seq;
        logic [31:0] cur_len;
        logic [31:0] cur_hdr;
        logic [31:0] cur_end;
        logic [31:0] ent_end;
        logic [31:0] add;
        logic [31:0] tail_seq;
        int          pos;
        int          nbuf;
        cached_seg_t c;
        seg_end = s.seq + {16'd0, s.len};
        if (s.kind == KIND_RESTART)
        begin
            seg_cache.delete();
            next_seq = s.seq;
            push_delivery(ST_OK, DL_NONE, '0, '0, '0, 1'b1);
            return;
        end
        if (!enable_q || s.len == 16'd0)
        begin
            push_delivery(ST_OK, DL_RAW, s.seq, s.len, '0, 1'b1);
            return;
        end
        if (seg_end == next_seq || seq_before(seg_end, next_seq))
        begin
            push_delivery(ST_BEFORE, DL_RAW, s.seq, s.len, '0, 1'b1);
            return;
        end
        if (seq_before(next_seq, s.seq))
        begin
            if (seg_cache.size() >= TABLE_DEPTH)
            begin
                push_delivery(ST_FULL, DL_NONE, '0, '0, '0, 1'b1);
                return;
            end
            pos = seg_cache.size();
            tail_seq = (pos > 0) ? seg_cache[pos-1].seq : 32'd0;
            if (pos > 0 && !(s.seq == tail_seq || seq_before(tail_seq, s.seq)))
            begin
                for (int i = 0; i < seg_cache.size(); i++)
                begin
                    if (s.seq == seg_cache[i].seq || seq_before(s.seq, seg_cache[i].seq))
                    begin
                        pos = i;
                        break;
                    end
                end
            end
            c.seq = s.seq;
            c.len = s.len;
            c.hdr = s.hdr;
            seg_cache.insert(pos, c);
            push_delivery(ST_CACHED, DL_NONE, '0, '0, '0, 1'b1);
            return;
        end
        ovl = (s.seq == next_seq) ? 32'd0 : seg_end - next_seq;
        if (seg_cache.size() == 0 || seq_before(seg_end, seg_cache[0].seq))
        begin
            next_seq = seg_end;
            push_delivery((ovl == 32'd0) ? ST_OK : ST_OVERLAP, DL_RAW, s.seq, s.len,
                          ovl[15:0], 1'b1);
            return;
        end
        cur_seq = s.seq;
        cur_len = {16'd0, s.len};
        cur_hdr = {24'd0, s.hdr};
        nbuf = 0;
        next_seq = seg_end;
        while (seg_cache.size() > 0)
        begin
            c = seg_cache[0];
            cur_end = cur_seq + cur_len;
            ent_end = c.seq + {16'd0, c.len};
            if (cur_end == c.seq)
                add = {16'd0, c.len};
            else if (seq_before(c.seq, cur_end))
            begin
                if (cur_end == ent_end || seq_before(ent_end, cur_end))
                begin
                    void'(seg_cache.pop_front());
                    continue;
                end
                add = ent_end - cur_end;
            end
            else
                break;
            if (cur_hdr + cur_len + add > {16'd0, buf_limit})
            begin
                push_delivery(ST_OK, DL_BUF, cur_seq, cur_len[15:0],
                              (nbuf == 0) ? ovl[15:0] : 16'd0, 1'b0);
                nbuf++;
                cur_seq = cur_end;
                cur_len = add;
                cur_hdr = {24'd0, c.hdr};
            end
            else
                cur_len = cur_len + add;
            next_seq = ent_end;
            void'(seg_cache.pop_front());
        end
        push_delivery(ST_OK, DL_BUF, cur_seq, cur_len[15:0],
                      (nbuf == 0) ? ovl[15:0] : 16'd0, 1'b1);
    endfunction

    function automatic void add_seg(logic k, logic [31:0] sq, logic [15:0] ln, logic [7:0] hd);
        segment_t s;
        s.kind = k;
        s.seq = sq;
        s.len = ln;
        s.hdr = hd;
        pending_segs.push_back(s);
    endfunction

    // build a burst of out-of-order pieces then the head that merges them
    function automatic void add_stream(logic [31:0] start);
        int          n;
        logic [31:0] offs[$];
        logic [15:0] lens[$];
        logic [31:0] p;
        int          j;
        logic [31:0] tmp_o;
        logic [15:0] tmp_l;
        n = $urandom_range(1, 8);
        p = start;
        for (int i = 0; i <= n; i++)
        begin
            offs.push_back(p);
            lens.push_back(16'($urandom_range(1, 3000)));
            if ($urandom_range(0, 3) == 0)
                p = p + lens[i] - $urandom_range(0, lens[i]);
            else
                p = p + lens[i] + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 50) : 0);
        end
        for (int i = n; i > 1; i--)
        begin
            j = $urandom_range(1, i);
            tmp_o = offs[i]; offs[i] = offs[j]; offs[j] = tmp_o;
            tmp_l = lens[i]; lens[i] = lens[j]; lens[j] = tmp_l;
        end
        for (int i = 1; i <= n; i++)
            add_seg(KIND_DATA, offs[i], lens[i], 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            add_seg(KIND_DATA, start - $urandom_range(1, 100), lens[0] + 16'd100,
                    8'($urandom_range(0, 255)));
        else
            add_seg(KIND_DATA, start, lens[0], 8'($urandom_range(0, 255)));
    endfunction

    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ENABLE)
            enable_q = value[0];
        else
            buf_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (pending_segs.size() > 0 || in_valid || expected_deliveries.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        logic [31:0] b;
        int          r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                b = $urandom;
                add_seg(KIND_RESTART, b, 16'($urandom), 8'($urandom));
                add_stream(b);
                i += 5;
            end
            else if (r < 85)
                add_seg(KIND_DATA, $urandom, 16'($urandom), 8'($urandom));
            else if (r < 95)
                add_seg(KIND_DATA, $urandom_range(0, 8000), 16'($urandom_range(0, 4000)),
                        8'($urandom));
            else
                add_seg(1'($urandom_range(0, 1)), $urandom, 16'($urandom), 8'($urandom));
        end
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            seq_number <= '0;
            seg_length <= '0;
            header_len <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_segs.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 14))
            begin
                in_valid <= 1'b1;
                kind <= pending_segs[0].kind;
                seq_number <= pending_segs[0].seq;
                seg_length <= pending_segs[0].len;
                header_len <= pending_segs[0].hdr;
                void'(pending_segs.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_out > 0)
        begin
            out_stall <= 1'b1;
            hold_out <= hold_out - 1;
        end
        else
            out_stall <= !quiet_out && ($urandom_range(0, 99) < 14);
    end

    always @(posedge clk)
    begin
        segment_t  s;
        delivery_t e;
        bit        active;
        if (rst_n)
        begin
            active = 1'b0;
            if (in_valid && !in_stall)
            begin
                s.kind = kind;
                s.seq = seq_number;
                s.len = seg_length;
                s.hdr = header_len;
                predict_reassembly(s);
                active = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                active = 1'b1;
                if (expected_deliveries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d seq=%h", status, out_seq);
                end
                else
                begin
                    e = expected_deliveries.pop_front();
                    if (e.status !== status || e.delivered !== delivered ||
                        e.seq !== out_seq || e.len !== out_length ||
                        e.ovl !== overlap_bytes || e.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch exp st=%0d dl=%0d seq=%h len=%0d ovl=%0d last=%0d",
                                e.status, e.delivered, e.seq, e.len, e.ovl, e.last);
                            $display(" act st=%0d dl=%0d seq=%h len=%0d ovl=%0d last=%0d",
                                status, delivered, out_seq, out_length, overlap_bytes, last);
                        end
                    end
                end
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
            if (idle_cycles > 20000)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        hold_out = 0;
        next_seq = '0;
        enable_q = 1'b1;
        buf_limit = MAXLEN_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        wait (rst_n);
        write_reg(CFG_MAXLEN, 16'd8192);
        write_reg(CFG_ENABLE, 16'd1);
        add_seg(KIND_DATA, 32'd0, 16'd0, 8'd0);
        add_seg(KIND_DATA, 32'd0, 16'd100, 8'd20);
        add_seg(KIND_DATA, 32'd50, 16'd10, 8'd20);
        add_seg(KIND_DATA, 32'd300, 16'd100, 8'd40);
        add_seg(KIND_DATA, 32'd200, 16'd100, 8'd40);
        add_seg(KIND_DATA, 32'd200, 16'd50, 8'd40);
        add_seg(KIND_DATA, 32'd90, 16'd50, 8'hFF);
        add_seg(KIND_DATA, 32'd700, 16'd10, 8'd0);
        add_seg(KIND_DATA, 32'd150, 16'd20, 8'd0);
        add_seg(KIND_RESTART, 32'hFFFF_FFF0, 16'hFFFF, 8'hFF);
        for (int i = 1; i <= 17; i++)
            add_seg(KIND_DATA, 32'hFFFF_FFF0 + 32'(i * 100), 16'd10, 8'd0);
        add_seg(KIND_DATA, 32'hFFFF_FFF0, 16'hFFFF, 8'hFF);
        add_seg(KIND_DATA, 32'hFFFF_0000, 16'd16, 8'd0);
        drain_and_settle();
        // let the result side back up while the sender keeps pushing
        hold_out = 300;
        random_phase(60);
        drain_and_settle();
        write_reg(CFG_MAXLEN, 16'd1);
        random_phase(40);
        drain_and_settle();
        write_reg(CFG_MAXLEN, 16'd2000);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        random_phase(50);
        drain_and_settle();
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        write_reg(CFG_ENABLE, 16'd0);
        random_phase(30);
        drain_and_settle();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_MAXLEN, 16'hFFFF);
        random_phase(80);
        drain_and_settle();
        write_reg(CFG_MAXLEN, 16'd3000);
        random_phase(40);
        drain_and_settle();
        if (mismatches == 0 && expected_deliveries.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("TB_ERROR");
        $finish;
    end
endmodule

/* files.f */
sv/tsr_pkg.sv
sv/tsr_ctrl.sv
sv/tsr_datapath.sv
sv/tcp_segment_reassembly_top.sv
verif/testbench.sv
